// ===== design/sld_pkg.sv =====
// Package: shared constants and types for the sidechain level detector.
package sld_pkg;

  localparam int unsigned MaxChannelsDef    = 8;
  localparam int unsigned MaxBlockFramesDef = 4096;
  localparam int unsigned SampleWidthDef    = 16;

  localparam int unsigned LevelW = 16;
  localparam int unsigned CoefW  = 16;
  localparam int unsigned EnvW   = 32;
  localparam int unsigned SqW    = 42;

  localparam logic [1:0] RegChannelCount = 2'd0;
  localparam logic [1:0] RegAttackCoef   = 2'd1;
  localparam logic [1:0] RegReleaseCoef  = 2'd2;
  localparam logic [1:0] RegThreshold    = 2'd3;

  typedef enum logic [2:0] {
    StIdle,
    StMix,
    StDiv,
    StUpd,
    StRes,
    StSqrt,
    StOut
  } state_e;

  typedef struct packed {
    logic start;
  } div_ctl_t;

endpackage

// ===== design/sld_serial_div.sv =====
// Restoring divider that retires one quotient bit per cycle.
module sld_serial_div import sld_pkg::*; #(
  parameter int unsigned NumW = 42,
  parameter int unsigned DenW = 16
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  div_ctl_t        ctl_i,
  input  logic [NumW-1:0] num_i,
  input  logic [DenW-1:0] den_i,
  output logic            done_o,
  output logic [NumW-1:0] quo_o
);

  localparam int unsigned CntW = $clog2(NumW + 1);

  logic [NumW-1:0] quo_q, quo_d;
  logic [DenW:0]   rem_q, rem_d;
  logic [DenW-1:0] den_q, den_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            run_q, run_d, done_q, done_d;
  logic [DenW:0]   trial;

  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    run_d  = run_q;
    done_d = 1'b0;
    trial  = {rem_q[DenW-1:0], quo_q[NumW-1]};
    if (ctl_i.start) begin
      quo_d = num_i;
      rem_d = '0;
      den_d = den_i;
      cnt_d = CntW'(NumW);
      run_d = 1'b1;
    end else if (run_q) begin
      if (trial >= {1'b0, den_q}) begin
        rem_d = trial - {1'b0, den_q};
        quo_d = {quo_q[NumW-2:0], 1'b1};
      end else begin
        rem_d = trial;
        quo_d = {quo_q[NumW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

// ===== design/sidechain_level_detector_core.sv =====
// Top level: sidechain level detector with serial mix, divide, envelope and root.
// One frame per item. A plain frame sums its channels one at a time, divides the
// magnitude of the sum by the channel count in the bit-serial divider for the
// channel average (42 quotient bits), runs the two envelope-update states and
// returns to the idle state, which takes the next beat. A block-end frame adds
// the mean-square division followed by a bit-pair square root of 21 result
// bits, and a state that loads the result register; that state waits while an
// earlier result beat is still unaccepted.
module sidechain_level_detector_core import sld_pkg::*; #(
  parameter int unsigned MAX_CHANNELS     = MaxChannelsDef,
  parameter int unsigned MAX_BLOCK_FRAMES = MaxBlockFramesDef,
  parameter int unsigned SAMPLE_WIDTH     = SampleWidthDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [3:0]                     paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready,
  input  logic                           valid_i,
  output logic                           ready_o,
  input  logic signed [SAMPLE_WIDTH-1:0] sample_ch0_i,
  input  logic signed [SAMPLE_WIDTH-1:0] sample_ch1_i,
  input  logic signed [SAMPLE_WIDTH-1:0] sample_ch2_i,
  input  logic signed [SAMPLE_WIDTH-1:0] sample_ch3_i,
  input  logic signed [SAMPLE_WIDTH-1:0] sample_ch4_i,
  input  logic signed [SAMPLE_WIDTH-1:0] sample_ch5_i,
  input  logic signed [SAMPLE_WIDTH-1:0] sample_ch6_i,
  input  logic signed [SAMPLE_WIDTH-1:0] sample_ch7_i,
  input  logic                           block_end_i,
  output logic                           valid_o,
  input  logic                           ready_i,
  output logic [LevelW-1:0]              rms_level_o,
  output logic [LevelW-1:0]              peak_level_o,
  output logic [LevelW-1:0]              envelope_level_o,
  output logic                           is_active_o,
  output logic                           block_overflow_o
);

  localparam int unsigned SumW  = SAMPLE_WIDTH + 3;
  localparam int unsigned MagW  = SAMPLE_WIDTH;
  localparam int unsigned ChW   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int unsigned FcW   = $clog2(MAX_BLOCK_FRAMES + 1);
  localparam int unsigned DivW  = (SumW > SqW) ? SumW : SqW;
  localparam int unsigned DenW  = (FcW > 4) ? FcW : 4;
  localparam int unsigned RtW   = SqW / 2;
  localparam int unsigned RtCW  = $clog2(RtW + 1);
  localparam logic [SqW-1:0] SqMax = '1;
  localparam logic [FcW-1:0] FcMax = FcW'(MAX_BLOCK_FRAMES);

  logic [3:0]        chan_cnt_q;
  logic [CoefW-1:0]  attack_q, release_q, thresh_q;
  logic              wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chan_cnt_q <= 4'd2;
      attack_q   <= 16'd65387;
      release_q  <= 16'd65524;
      thresh_q   <= 16'd16;
    end else if (wr_en && paddr[1:0] == 2'b00 && paddr[3:2] == RegChannelCount) begin
      chan_cnt_q <= pwdata[3:0];
    end else if (wr_en && paddr[1:0] == 2'b00 && paddr[3:2] == RegAttackCoef) begin
      attack_q <= pwdata[15:0];
    end else if (wr_en && paddr[1:0] == 2'b00 && paddr[3:2] == RegReleaseCoef) begin
      release_q <= pwdata[15:0];
    end else if (wr_en && paddr[1:0] == 2'b00 && paddr[3:2] == RegThreshold) begin
      thresh_q <= pwdata[15:0];
    end
  end

  always_comb begin
    prdata = '0;
    unique case (paddr[3:2])
      RegChannelCount: prdata = {28'd0, chan_cnt_q};
      RegAttackCoef:   prdata = {16'd0, attack_q};
      RegReleaseCoef:  prdata = {16'd0, release_q};
      RegThreshold:    prdata = {16'd0, thresh_q};
      default:         prdata = '0;
    endcase
  end

  // effective channel count
  logic [ChW:0] nch;
  always_comb begin
    priority if (chan_cnt_q == 4'd0) nch = (ChW+1)'(1);
    else if (32'(chan_cnt_q) > MAX_CHANNELS) nch = (ChW+1)'(MAX_CHANNELS);
    else nch = (ChW+1)'(chan_cnt_q);
  end

  state_e state_q, state_d;

  logic signed [SAMPLE_WIDTH-1:0] ch_q [MAX_CHANNELS];
  logic signed [SAMPLE_WIDTH-1:0] ch_d [MAX_CHANNELS];
  logic                           end_q;
  logic [ChW:0]                   idx_q, idx_d;
  logic signed [SumW-1:0]         sum_q, sum_d;
  logic [MagW-1:0]                mag_q, mag_d;
  logic [EnvW-1:0]                env_q, env_d;
  logic [MagW-1:0]                peak_q, peak_d;
  logic [SqW-1:0]                 sq_q, sq_d;
  logic [FcW-1:0]                 fc_q, fc_d;
  logic                           ovf_q, ovf_d;
  logic [EnvW+CoefW:0]            prod_q, prod_d;
  logic [EnvW+CoefW:0]            prod2_q, prod2_d;
  logic [SqW-1:0]                 rx_q, rx_d;
  logic [RtW-1:0]                 rr_q, rr_d;
  logic [RtCW-1:0]                rc_q, rc_d;
  logic [SqW+1:0]                 rrem_q, rrem_d;
  logic                           vo_q, vo_d;
  logic [LevelW-1:0]              rms_q, rms_d, pko_q, pko_d, envo_q, envo_d;
  logic                           act_q, act_d, ovo_q, ovo_d;
  logic                           u_div_done_seen, seen_q, seen_d;

  div_ctl_t        dctl;
  logic [DivW-1:0] dnum, dquo;
  logic [DenW-1:0] dden;
  logic            ddone;

  sld_serial_div #(.NumW(DivW), .DenW(DenW)) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (dctl),
    .num_i  (dnum),
    .den_i  (dden),
    .done_o (ddone),
    .quo_o  (dquo)
  );

  logic [SumW-1:0]  abs_sum;
  logic [2*MagW-1:0] msq;
  logic [SqW:0]     sq_add;
  logic [EnvW-1:0]  magq;
  logic [CoefW:0]   coef, coefn;
  logic [EnvW+CoefW+1:0] acc;
  logic [RtW+1:0]   rtrial;
  logic [SqW+1:0]   rcur;
  logic             accept_in;
  logic [MagW:0]    pk_sat;

  assign accept_in = valid_i && ready_o;
  assign abs_sum   = sum_q[SumW-1] ? SumW'(-sum_q) : SumW'(sum_q);

  assign ch_d[0] = sample_ch0_i;
  if (MAX_CHANNELS > 1) begin : g_c1
    assign ch_d[1] = sample_ch1_i;
  end
  if (MAX_CHANNELS > 2) begin : g_c2
    assign ch_d[2] = sample_ch2_i;
  end
  if (MAX_CHANNELS > 3) begin : g_c3
    assign ch_d[3] = sample_ch3_i;
  end
  if (MAX_CHANNELS > 4) begin : g_c4
    assign ch_d[4] = sample_ch4_i;
  end
  if (MAX_CHANNELS > 5) begin : g_c5
    assign ch_d[5] = sample_ch5_i;
  end
  if (MAX_CHANNELS > 6) begin : g_c6
    assign ch_d[6] = sample_ch6_i;
  end
  if (MAX_CHANNELS > 7) begin : g_c7
    assign ch_d[7] = sample_ch7_i;
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: if (accept_in) state_d = StMix;
      StMix:  if (idx_q == nch - 1'b1) state_d = StDiv;
      StDiv:  if (ddone) state_d = StUpd;
      StUpd:  state_d = StRes;
      StRes:  state_d = end_q ? StSqrt : StIdle;
      StSqrt: if (rc_q == '0) state_d = StOut;
      StOut:  if (!vo_q) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  // datapath
  always_comb begin
    idx_d  = idx_q;
    sum_d  = sum_q;
    mag_d  = mag_q;
    env_d  = env_q;
    peak_d = peak_q;
    sq_d   = sq_q;
    fc_d   = fc_q;
    ovf_d  = ovf_q;
    prod_d = prod_q;
    prod2_d = prod2_q;
    rx_d   = rx_q;
    rr_d   = rr_q;
    rc_d   = rc_q;
    rrem_d = rrem_q;
    vo_d   = vo_q && !ready_i;
    rms_d  = rms_q;
    pko_d  = pko_q;
    envo_d = envo_q;
    act_d  = act_q;
    ovo_d  = ovo_q;
    dctl   = '{start: 1'b0};
    dnum   = DivW'(abs_sum);
    dden   = DenW'(nch);
    msq    = '0;
    sq_add = '0;
    magq   = '0;
    coef   = '0;
    coefn  = '0;
    acc    = '0;
    rtrial = '0;
    rcur   = '0;
    pk_sat = '0;
    unique case (state_q)
      StIdle: begin
        idx_d = '0;
        sum_d = '0;
      end
      StMix: begin
        sum_d = sum_q + SumW'(ch_q[idx_q[ChW-1:0]]);
        idx_d = idx_q + 1'b1;
      end
      StDiv: begin
        if (idx_q != '0) begin
          dctl.start = 1'b1;
          idx_d = '0;
        end
        if (ddone) begin
          mag_d = MagW'(dquo);
        end
      end
      StUpd: begin
        msq    = mag_q * mag_q;
        sq_add = {1'b0, sq_q} + (SqW+1)'(msq);
        sq_d   = sq_add[SqW] ? SqMax : sq_add[SqW-1:0];
        if (mag_q > peak_q) peak_d = mag_q;
        if (fc_q >= FcMax) ovf_d = 1'b1;
        else fc_d = fc_q + 1'b1;
        magq  = EnvW'(mag_q) << 16;
        coef  = (magq > env_q) ? {1'b0, attack_q} : {1'b0, release_q};
        coefn = 17'h10000 - coef;
        prod_d  = (EnvW+CoefW+1)'(coef * env_q);
        prod2_d = (EnvW+CoefW+1)'(coefn * {16'd0, mag_q});
      end
      StRes: begin
        acc = (EnvW+CoefW+2)'(prod_q) + ((EnvW+CoefW+2)'(prod2_q) << 16)
            + (EnvW+CoefW+2)'(32768);
        env_d = (acc[EnvW+CoefW+1:CoefW] > (EnvW+2)'({EnvW{1'b1}})) ? '1
              : acc[EnvW+CoefW-1:CoefW];
        if (end_q) begin
          dctl.start = 1'b1;
          dnum = DivW'(sq_q);
          dden = (fc_q == '0) ? DenW'(1) : DenW'(fc_q);
          rc_d = RtCW'(RtW);
          rr_d = '0;
          rrem_d = '0;
        end
      end
      StSqrt: begin
        dnum = DivW'(sq_q);
        dden = DenW'(fc_q);
        if (ddone) begin
          rx_d = SqW'(dquo);
        end
        if (u_div_done_seen && rc_q != '0) begin
          rcur   = {rrem_q[SqW-1:0], rx_q[SqW-1:SqW-2]};
          rtrial = {rr_q, 2'b01};
          if (rcur >= (SqW+2)'(rtrial)) begin
            rrem_d = rcur - (SqW+2)'(rtrial);
            rr_d   = {rr_q[RtW-2:0], 1'b1};
          end else begin
            rrem_d = rcur;
            rr_d   = {rr_q[RtW-2:0], 1'b0};
          end
          rx_d = {rx_q[SqW-3:0], 2'b00};
          rc_d = rc_q - 1'b1;
        end
      end
      StOut: ;
      default: ;
    endcase
    if (state_q == StOut && !vo_q) begin
      vo_d  = 1'b1;
      rms_d = (rr_q > RtW'(32768)) ? LevelW'(32768) : LevelW'(rr_q);
      pk_sat = {1'b0, peak_q};
      pko_d = (pk_sat > (MagW+1)'(32768)) ? LevelW'(32768) : LevelW'(peak_q);
      envo_d = env_q[EnvW-1:16];
      act_d  = env_q > {thresh_q, 16'd0};
      ovo_d  = ovf_q;
      peak_d = '0;
      sq_d   = '0;
      fc_d   = '0;
      ovf_d  = 1'b0;
    end
  end

  assign u_div_done_seen = seen_q;
  always_comb begin
    seen_d = seen_q;
    if (state_q == StRes) seen_d = 1'b0;
    else if (state_q == StSqrt && ddone) seen_d = 1'b1;
  end

  // outputs of the control block
  always_comb begin
    ready_o = (state_q == StIdle);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      idx_q   <= '0;
      env_q   <= '0;
      peak_q  <= '0;
      sq_q    <= '0;
      fc_q    <= '0;
      ovf_q   <= 1'b0;
      vo_q    <= 1'b0;
      rc_q    <= '0;
      seen_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= (state_q == StMix && state_d == StDiv) ? (ChW+1)'(1) : idx_d;
      env_q   <= env_d;
      peak_q  <= peak_d;
      sq_q    <= sq_d;
      fc_q    <= fc_d;
      ovf_q   <= ovf_d;
      vo_q    <= vo_d;
      rc_q    <= rc_d;
      seen_q  <= seen_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_in) begin
      ch_q  <= ch_d;
      end_q <= block_end_i;
    end
    sum_q   <= sum_d;
    mag_q   <= mag_d;
    prod_q  <= prod_d;
    prod2_q <= prod2_d;
    rx_q    <= rx_d;
    rr_q    <= rr_d;
    rrem_q  <= rrem_d;
    rms_q   <= rms_d;
    pko_q   <= pko_d;
    envo_q  <= envo_d;
    act_q   <= act_d;
    ovo_q   <= ovo_d;
  end

  assign valid_o          = vo_q;
  assign rms_level_o      = rms_q;
  assign peak_level_o     = pko_q;
  assign envelope_level_o = envo_q;
  assign is_active_o      = act_q;
  assign block_overflow_o = ovo_q;

endmodule

// ===== design/sld_checker.sv =====
// Checker: port-level properties of the sidechain level detector, bound to the top.
module sld_checker import sld_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              valid_i,
  input logic              ready_o,
  input logic              valid_o,
  input logic              ready_i,
  input logic [LevelW-1:0] rms_level_o,
  input logic [LevelW-1:0] peak_level_o,
  input logic              block_overflow_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !ready_i |=> valid_o && $stable(rms_level_o) && $stable(peak_level_o)
                            && $stable(block_overflow_o))
    else $error("result beat changed while stalled");

  a_rms_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> rms_level_o <= 16'd32768)
    else $error("rms out of range");

  a_peak_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> peak_level_o <= 16'd32768)
    else $error("peak out of range");

  a_no_take_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && ready_o |=> !ready_o)
    else $error("accepted a frame while busy");

endmodule

bind sidechain_level_detector_core sld_checker u_sld_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .valid_i          (valid_i),
  .ready_o          (ready_o),
  .valid_o          (valid_o),
  .ready_i          (ready_i),
  .rms_level_o      (rms_level_o),
  .peak_level_o     (peak_level_o),
  .block_overflow_o (block_overflow_o)
);
